>>> design/mlbc_pkg.sv
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared constants, codes and types of the multi-LED blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

  // Number of LEDs driven, numbered from 1 on the ports.
  localparam int LED_COUNT = 8;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int TICKS_W   = 16;
  localparam int LED_W     = 4;
  localparam int MODE_W    = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Queue depths must be powers of two; the pointers wrap by overflow.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALL_OFF = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD    = 2'd3;

  // Light and device mode codes.
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MEDIUM = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUICK  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SW_FLASH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_OFF  = 3'd6;

  // Reset values of the flash timing registers.
  localparam logic [TICKS_W-1:0] RST_SLOW_ON    = 16'd1000;
  localparam logic [TICKS_W-1:0] RST_SLOW_OFF   = 16'd200;
  localparam logic [TICKS_W-1:0] RST_MEDIUM_ON  = 16'd600;
  localparam logic [TICKS_W-1:0] RST_MEDIUM_OFF = 16'd200;
  localparam logic [TICKS_W-1:0] RST_QUICK_ON   = 16'd300;
  localparam logic [TICKS_W-1:0] RST_QUICK_OFF  = 16'd200;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_ALL_OFF
  } op_kind_t;

  // A classified command as it travels from the front end to the back end.
  typedef struct packed {
    op_kind_t              kind;
    logic [IDX_W-1:0]      idx;
    logic                  wr;
    logic                  report;
    logic [LED_W-1:0]      led;
    logic [MODE_W-1:0]     mode;
    logic                  bad;
    logic [TICKS_W-1:0]    on_t;
    logic [TICKS_W-1:0]    off_t;
  } op_t;

  // One result event.
  typedef struct packed {
    logic [LED_W-1:0]  led;
    logic [MODE_W-1:0] mode;
    logic              bad;
    logic              last;
  } ev_t;

endpackage

>>> design/mlbc_front.sv
// ----------------------------------------------------------------------------
// mlbc_front
// Holds the configuration registers and turns each accepted input item into
// a classified operation for the back end.
// ----------------------------------------------------------------------------
module mlbc_front
  import mlbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [LED_W-1:0]     in_led_number,
  input  logic [MODE_W-1:0]    in_light_mode,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output op_t                  q_op
);

  logic               sw_flash_r;
  logic [TICKS_W-1:0] slow_on_r;
  logic [TICKS_W-1:0] slow_off_r;
  logic [TICKS_W-1:0] medium_on_r;
  logic [TICKS_W-1:0] medium_off_r;
  logic [TICKS_W-1:0] quick_on_r;
  logic [TICKS_W-1:0] quick_off_r;

  logic               led_ok;
  logic               is_flash;
  logic               is_level;
  logic [TICKS_W-1:0] sel_on;
  logic [TICKS_W-1:0] sel_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_flash_r   <= 1'b1;
      slow_on_r    <= RST_SLOW_ON;
      slow_off_r   <= RST_SLOW_OFF;
      medium_on_r  <= RST_MEDIUM_ON;
      medium_off_r <= RST_MEDIUM_OFF;
      quick_on_r   <= RST_QUICK_ON;
      quick_off_r  <= RST_QUICK_OFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SW_FLASH:   sw_flash_r   <= cfg_data[0];
        REG_SLOW_ON:    slow_on_r    <= cfg_data;
        REG_SLOW_OFF:   slow_off_r   <= cfg_data;
        REG_MEDIUM_ON:  medium_on_r  <= cfg_data;
        REG_MEDIUM_OFF: medium_off_r <= cfg_data;
        REG_QUICK_ON:   quick_on_r   <= cfg_data;
        REG_QUICK_OFF:  quick_off_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign led_ok   = (in_led_number != '0) && (in_led_number <= LED_W'(LED_COUNT));
  assign is_level = (in_light_mode == MODE_OFF) || (in_light_mode == MODE_ON);
  assign is_flash = (in_light_mode == MODE_SLOW) || (in_light_mode == MODE_MEDIUM) ||
                    (in_light_mode == MODE_QUICK);

  always_comb begin
    unique case (in_light_mode)
      MODE_SLOW: begin
        sel_on  = slow_on_r;
        sel_off = slow_off_r;
      end
      MODE_MEDIUM: begin
        sel_on  = medium_on_r;
        sel_off = medium_off_r;
      end
      MODE_QUICK: begin
        sel_on  = quick_on_r;
        sel_off = quick_off_r;
      end
      default: begin
        sel_on  = '0;
        sel_off = '0;
      end
    endcase
  end

  always_comb begin
    unique case (in_cmd)
      CMD_TICK:    q_op.kind = OP_TICK;
      CMD_ALL_OFF: q_op.kind = OP_ALL_OFF;
      default:     q_op.kind = OP_SET;
    endcase
    // A set with a valid LED number clears the entry; only a software-timed flash loads times.
    q_op.idx    = IDX_W'(in_led_number - LED_W'(1));
    q_op.wr     = led_ok;
    q_op.report = !led_ok || is_level || (is_flash && !sw_flash_r);
    q_op.led    = in_led_number;
    q_op.mode   = led_ok ? in_light_mode : MODE_OFF;
    q_op.bad    = !led_ok;
    q_op.on_t   = (is_flash && sw_flash_r) ? sel_on : '0;
    q_op.off_t  = (is_flash && sw_flash_r) ? sel_off : '0;
  end

  // The reserved command is accepted and dropped.
  assign q_push = push && !q_full && (in_cmd != CMD_RSVD);

endmodule

>>> design/mlbc_cmd_q.sv
// ----------------------------------------------------------------------------
// mlbc_cmd_q
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module mlbc_cmd_q
  import mlbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic full,
  output logic rd_valid,
  output op_t  rd_op,
  input  logic rd_en
);

  op_t                q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r;
  logic [CMDQ_AW-1:0] rptr_r;
  logic [CMDQ_AW:0]   cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign full     = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_op    = q_r[rptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_rd) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wptr_r] <= wr_op;
    end
  end

endmodule

>>> design/mlbc_back.sv
// ----------------------------------------------------------------------------
// mlbc_back
// Carries out operations on the per-LED blink entries and queues the events;
// tick scans and all-off take one entry per cycle unless a full queue stalls.
// ----------------------------------------------------------------------------
module mlbc_back
  import mlbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic op_valid,
  input  op_t  op,
  output logic op_pop,
  input  logic pop,
  output logic empty,
  output ev_t  head
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CLEAR
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Per-LED entries.
  logic [TICKS_W-1:0]   on_r  [LED_COUNT];
  logic [TICKS_W-1:0]   off_r [LED_COUNT];
  logic [TICKS_W-1:0]   rem_r [LED_COUNT];
  logic [LED_COUNT-1:0] lit_r;
  logic [LED_COUNT-1:0] started_r;

  // Entry write port.
  logic               ent_we;
  logic [IDX_W-1:0]   ent_idx;
  logic [TICKS_W-1:0] ent_on;
  logic [TICKS_W-1:0] ent_off;
  logic [TICKS_W-1:0] ent_rem;
  logic               ent_lit;
  logic               ent_started;

  // Tick step on the entry under the scan index.
  logic [TICKS_W-1:0]   cur_on;
  logic [TICKS_W-1:0]   cur_off;
  logic [TICKS_W-1:0]   cur_rem;
  logic                 cur_lit;
  logic                 cur_started;
  logic                 step_emit;
  logic                 new_lit;
  logic [TICKS_W-1:0]   new_rem;
  logic [LED_COUNT-1:0] emit_mask;
  logic                 later_emit;
  logic                 last_idx;
  logic                 step_go;

  // Output queue.
  ev_t                outq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] out_wptr_r;
  logic [OUTQ_AW-1:0] out_rptr_r;
  logic [OUTQ_AW:0]   out_cnt_r;
  logic               out_full;
  logic               ev_push;
  ev_t                ev;
  logic               do_pop;

  assign cur_on      = on_r[idx_r];
  assign cur_off     = off_r[idx_r];
  assign cur_rem     = rem_r[idx_r];
  assign cur_lit     = lit_r[idx_r];
  assign cur_started = started_r[idx_r];
  assign last_idx    = (idx_r == IDX_W'(LED_COUNT - 1));

  assign step_emit = (cur_on != '0) && (!cur_started || (cur_rem == '0));
  assign new_lit   = !cur_started ? 1'b1 : ((cur_rem == '0) ? !cur_lit : cur_lit);

  always_comb begin
    if (cur_on == '0) begin
      new_rem = cur_rem;
    end else if (!cur_started) begin
      new_rem = cur_on;
    end else if (cur_rem == '0) begin
      new_rem = new_lit ? cur_on : cur_off;
    end else begin
      new_rem = cur_rem - 1'b1;
    end
  end

  // An event is the last of a tick when no later entry of the scan will emit.
  // Later entries are untouched so far, so their present state decides.
  always_comb begin
    for (int j = 0; j < LED_COUNT; j++) begin
      emit_mask[j] = (on_r[j] != '0) && (!started_r[j] || (rem_r[j] == '0)) &&
                     (IDX_W'(j) > idx_r);
    end
    later_emit = |emit_mask;
  end

  assign out_full = (out_cnt_r == (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign empty    = (out_cnt_r == '0);
  assign head     = outq_r[out_rptr_r];
  assign do_pop   = pop && !empty;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    op_pop      = 1'b0;
    step_go     = 1'b0;
    ev_push     = 1'b0;
    ev          = '{led: op.led, mode: op.mode, bad: op.bad, last: 1'b1};
    ent_we      = 1'b0;
    ent_idx     = idx_r;
    ent_on      = cur_on;
    ent_off     = cur_off;
    ent_rem     = new_rem;
    ent_lit     = new_lit;
    ent_started = cur_started || (cur_on != '0);
    unique case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          unique case (op.kind)
            OP_TICK: begin
              op_pop    = 1'b1;
              idx_nxt   = '0;
              state_nxt = ST_TICK;
            end
            OP_ALL_OFF: begin
              op_pop    = 1'b1;
              idx_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            OP_SET: begin
              if (!(op.report && out_full)) begin
                op_pop      = 1'b1;
                ev_push     = op.report;
                ent_we      = op.wr;
                ent_idx     = op.idx;
                ent_on      = op.on_t;
                ent_off     = op.off_t;
                ent_rem     = '0;
                ent_lit     = 1'b0;
                ent_started = 1'b0;
              end
            end
            default: begin
              op_pop = 1'b1;
            end
          endcase
        end
      end
      ST_TICK: begin
        step_go = !(step_emit && out_full);
        if (step_go) begin
          ent_we  = 1'b1;
          ev_push = step_emit;
          ev      = '{led: LED_W'(idx_r) + LED_W'(1), mode: MODE_W'(new_lit),
                      bad: 1'b0, last: !later_emit};
        end
      end
      ST_CLEAR: begin
        step_go = !out_full;
        if (step_go) begin
          ent_we      = 1'b1;
          ent_on      = '0;
          ent_off     = '0;
          ent_rem     = '0;
          ent_lit     = 1'b0;
          ent_started = 1'b0;
          ev_push     = 1'b1;
          ev          = '{led: LED_W'(idx_r) + LED_W'(1), mode: MODE_OFF,
                          bad: 1'b0, last: last_idx};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (step_go) begin
      if (last_idx) begin
        state_nxt = ST_IDLE;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LED_COUNT; j++) begin
        on_r[j]  <= '0;
        off_r[j] <= '0;
        rem_r[j] <= '0;
      end
      lit_r     <= '0;
      started_r <= '0;
    end else if (ent_we) begin
      on_r[ent_idx]      <= ent_on;
      off_r[ent_idx]     <= ent_off;
      rem_r[ent_idx]     <= ent_rem;
      lit_r[ent_idx]     <= ent_lit;
      started_r[ent_idx] <= ent_started;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wptr_r <= '0;
      out_rptr_r <= '0;
      out_cnt_r  <= '0;
    end else begin
      if (ev_push) begin
        out_wptr_r <= out_wptr_r + 1'b1;
      end
      if (do_pop) begin
        out_rptr_r <= out_rptr_r + 1'b1;
      end
      if (ev_push && !do_pop) begin
        out_cnt_r <= out_cnt_r + 1'b1;
      end else if (do_pop && !ev_push) begin
        out_cnt_r <= out_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_push) begin
      outq_r[out_wptr_r] <= ev;
    end
  end

`ifndef SYNTHESIS
  a_outq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= (OUTQ_AW+1)'(OUTQ_DEPTH))
    else $error("output queue count above its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> !out_full)
    else $error("event pushed into a full output queue");

  a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && !step_go) |=> $stable(idx_r))
    else $error("scan index moved during a stall");

  a_started_has_on: assert property (@(posedge clk) disable iff (!rst_n)
    started_r[idx_r] |-> (on_r[idx_r] != '0))
    else $error("entry started without an on time");
`endif

endmodule

>>> design/multi_led_blink_controller.sv
// ----------------------------------------------------------------------------
// multi_led_blink_controller
// Blink controller for a row of guide LEDs: set, all-off and tick commands
// in, level and flash events out.
// ----------------------------------------------------------------------------
//  Channel  Ports                                         Transfer when
//  input    in_cmd, in_led_number, in_light_mode          push && !full
//  result   out_led, out_device_mode, out_bad_index,      pop && !empty
//           out_last
//  config   cfg_index, cfg_data                           cfg_wr_en
//
// A set command is carried out as it is dequeued. A tick or an all-off command
// is dequeued first; after that the LED entries are visited one by one, in order,
// through a single update path.
// The front end keeps accepting into a two-entry operation queue while the
// back end works; a full result queue stalls the entry scan in place.
// Reset is synchronous; it restores the register defaults and clears all LED
// entries and both queues at once.
// ----------------------------------------------------------------------------
module multi_led_blink_controller
  import mlbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [LED_W-1:0]     in_led_number,
  input  logic [MODE_W-1:0]    in_light_mode,
  output logic                 empty,
  input  logic                 pop,
  output logic [LED_W-1:0]     out_led,
  output logic [MODE_W-1:0]    out_device_mode,
  output logic                 out_bad_index,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data
);

  logic q_push;
  op_t  q_wr_op;
  logic q_valid;
  op_t  q_rd_op;
  logic q_pop;
  ev_t  head;

  mlbc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .in_cmd        (in_cmd),
    .in_led_number (in_led_number),
    .in_light_mode (in_light_mode),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (full),
    .q_push        (q_push),
    .q_op          (q_wr_op)
  );

  mlbc_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_op    (q_wr_op),
    .full     (full),
    .rd_valid (q_valid),
    .rd_op    (q_rd_op),
    .rd_en    (q_pop)
  );

  mlbc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_valid),
    .op       (q_rd_op),
    .op_pop   (q_pop),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign out_led         = head.led;
  assign out_device_mode = head.mode;
  assign out_bad_index   = head.bad;
  assign out_last        = head.last;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the multi-LED blink controller. A short table of
// directed commands covers reset timing, bad LED numbers, unknown modes,
// device flash codes and the first on/off toggles. Random command phases
// follow, each under its own flash timing. A built-in predictor tracks every
// LED entry and checks each event popped from the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import mlbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 4 * (LED_COUNT + 1) + 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 47;
  localparam int PHASE_COUNT    = 8;

  // Timing registers in order: slow on/off, medium on/off, quick on/off.
  typedef logic [5:0][TICKS_W-1:0] timing_set_t;

  localparam timing_set_t RESET_TIMING = {RST_QUICK_OFF, RST_QUICK_ON,
                                          RST_MEDIUM_OFF, RST_MEDIUM_ON,
                                          RST_SLOW_OFF, RST_SLOW_ON};
  // Slow never starts, medium stays on, quick toggles with no off time.
  localparam timing_set_t EDGE_TIMING  = {16'd0, 16'd1, 16'd0, 16'hFFFF,
                                          16'hFFFF, 16'd0};

  typedef struct packed {
    bit                is_cfg;
    bit                sw;
    timing_set_t       timing;
    logic [CMD_W-1:0]  cmd;
    logic [LED_W-1:0]  led;
    logic [MODE_W-1:0] mode;
    bit                typed;
    ev_t               want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [LED_W-1:0]     in_led_number = '0;
  logic [MODE_W-1:0]    in_light_mode = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [LED_W-1:0]     out_led;
  logic [MODE_W-1:0]    out_device_mode;
  logic                 out_bad_index;
  logic                 out_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICKS_W-1:0]   cfg_data = '0;

  multi_led_blink_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_cmd          (in_cmd),
    .in_led_number   (in_led_number),
    .in_light_mode   (in_light_mode),
    .empty           (empty),
    .pop             (pop),
    .out_led         (out_led),
    .out_device_mode (out_device_mode),
    .out_bad_index   (out_bad_index),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted LED entries and register copy.
  logic [TICKS_W-1:0] led_on_len   [LED_COUNT];
  logic [TICKS_W-1:0] led_off_len  [LED_COUNT];
  logic [TICKS_W-1:0] led_left     [LED_COUNT];
  bit                 led_lit      [LED_COUNT];
  bit                 led_running  [LED_COUNT];
  bit                 flash_sw;
  timing_set_t        flash_timing;

  ev_t pending_events[$];
  int  mismatch_count = 0;
  int  results_seen = 0;
  int  rx_wait = 0;
  int  rx_burst = 0;
  int  tx_burst = 0;
  int  idle_cycles = 0;

  function automatic ev_t make_event(input int led, input logic [MODE_W-1:0] mode,
                                     input bit bad);
    ev_t e;
    e.led  = LED_W'(led);
    e.mode = mode;
    e.bad  = bad;
    e.last = 1'b0;
    return e;
  endfunction

  // Works out the events one command causes and advances the LED entries.
  function automatic void blink_predict(input logic [CMD_W-1:0] cmd,
                                        input logic [LED_W-1:0] num,
                                        input logic [MODE_W-1:0] mode,
                                        ref ev_t evs[$]);
    int i;
    int k;
    if (cmd == CMD_TICK) begin
      for (i = 0; i < LED_COUNT; i++) begin
        if (led_on_len[i] == '0) continue;
        if (!led_running[i]) begin
          led_running[i] = 1'b1;
          led_lit[i]     = 1'b1;
          led_left[i]    = led_on_len[i];
          evs.push_back(make_event(i + 1, MODE_ON, 1'b0));
        end else if (led_left[i] == '0) begin
          led_lit[i]  = !led_lit[i];
          led_left[i] = led_lit[i] ? led_on_len[i] : led_off_len[i];
          evs.push_back(make_event(i + 1, led_lit[i] ? MODE_ON : MODE_OFF, 1'b0));
        end else begin
          led_left[i] = led_left[i] - 1'b1;
        end
      end
    end else if (cmd == CMD_SET) begin
      if (num < 1 || num > LED_COUNT) begin
        evs.push_back(make_event(int'(num), MODE_OFF, 1'b1));
      end else begin
        i = num - 1;
        led_on_len[i]  = '0;
        led_off_len[i] = '0;
        led_left[i]    = '0;
        led_lit[i]     = 1'b0;
        led_running[i] = 1'b0;
        if (mode == MODE_OFF || mode == MODE_ON) begin
          evs.push_back(make_event(int'(num), mode, 1'b0));
        end else if (mode >= MODE_SLOW && mode <= MODE_QUICK) begin
          if (flash_sw) begin
            k = (mode - MODE_SLOW) * 2;
            led_on_len[i]  = flash_timing[k];
            led_off_len[i] = flash_timing[k + 1];
          end else begin
            evs.push_back(make_event(int'(num), mode, 1'b0));
          end
        end
      end
    end else if (cmd == CMD_ALL_OFF) begin
      for (i = 0; i < LED_COUNT; i++) begin
        led_on_len[i]  = '0;
        led_off_len[i] = '0;
        led_left[i]    = '0;
        led_lit[i]     = 1'b0;
        led_running[i] = 1'b0;
        evs.push_back(make_event(i + 1, MODE_OFF, 1'b0));
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
  endfunction

  // Mostly short random waits, with occasional runs of back-to-back transfers.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic plan_row_t row_item(input logic [CMD_W-1:0] cmd,
                                         input logic [LED_W-1:0] led,
                                         input logic [MODE_W-1:0] mode);
    plan_row_t r;
    r      = '0;
    r.cmd  = cmd;
    r.led  = led;
    r.mode = mode;
    return r;
  endfunction

  function automatic plan_row_t row_typed(input logic [CMD_W-1:0] cmd,
                                          input logic [LED_W-1:0] led,
                                          input logic [MODE_W-1:0] mode,
                                          input logic [MODE_W-1:0] want_mode,
                                          input bit want_bad);
    plan_row_t r;
    r            = row_item(cmd, led, mode);
    r.typed      = 1'b1;
    r.want.led   = led;
    r.want.mode  = want_mode;
    r.want.bad   = want_bad;
    r.want.last  = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(input bit sw, input timing_set_t timing);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.sw     = sw;
    r.timing = timing;
    return r;
  endfunction

  task automatic check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Offers one command and records its expected events once it transfers.
  // Called and returns right after a falling edge.
  task automatic send_cmd(input plan_row_t row);
    int  gap;
    ev_t fresh[$];
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd        <= row.cmd;
    in_led_number <= row.led;
    in_light_mode <= row.mode;
    push          <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    blink_predict(row.cmd, row.led, row.mode, fresh);
    if (row.typed) begin
      pending_events.push_back(row.want);
    end else begin
      foreach (fresh[j]) pending_events.push_back(fresh[j]);
    end
    @(negedge clk);
  endtask

  // Waits until every expected event has arrived, then lets the block finish
  // any command that causes no event.
  task automatic drain;
    push <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_regs(input bit sw, input timing_set_t timing);
    drain();
    write_reg(REG_SW_FLASH, TICKS_W'(sw));
    write_reg(REG_SLOW_ON, timing[0]);
    write_reg(REG_SLOW_OFF, timing[1]);
    write_reg(REG_MEDIUM_ON, timing[2]);
    write_reg(REG_MEDIUM_OFF, timing[3]);
    write_reg(REG_QUICK_ON, timing[4]);
    write_reg(REG_QUICK_OFF, timing[5]);
    cfg_wr_en    <= 1'b0;
    flash_sw     = sw;
    flash_timing = timing;
  endtask

  // Result side: pop is driven at the falling edge, transfers are checked at
  // the rising edge.
  always @(posedge clk) begin
    ev_t got;
    ev_t want;
    if (rst_n && pop && !empty) begin
      got.led  = out_led;
      got.mode = out_device_mode;
      got.bad  = out_bad_index;
      got.last = out_last;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, got led %0d mode %0d bad %0d last %0d",
                 $time, got.led, got.mode, got.bad, got.last);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("out_led", int'(want.led), int'(got.led));
        check_field("out_device_mode", int'(want.mode), int'(got.mode));
        check_field("out_bad_index", int'(want.bad), int'(got.bad));
        check_field("out_last", int'(want.last), int'(got.last));
      end
      results_seen++;
      // A long hold-off lets the block back up until it stalls its input.
      if (results_seen == 40 || results_seen == 500) rx_wait = LONG_HOLD;
      else rx_wait = draw_gap(rx_burst);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || rx_wait > 0) begin
      pop <= 1'b0;
      if (rx_wait > 0) rx_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_wr_en) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    plan_row_t   row;
    timing_set_t timing;
    bit          sw;
    int          counted;
    int          pick;

    flash_sw     = 1'b1;
    flash_timing = RESET_TIMING;
    for (int i = 0; i < LED_COUNT; i++) begin
      led_on_len[i]  = '0;
      led_off_len[i] = '0;
      led_left[i]    = '0;
      led_lit[i]     = 1'b0;
      led_running[i] = 1'b0;
    end

    // Reset timing: levels, bad LED numbers, unknown mode and command.
    plan.push_back(row_item(CMD_TICK, 4'd0, MODE_OFF));
    plan.push_back(row_item(CMD_ALL_OFF, 4'd0, MODE_OFF));
    plan.push_back(row_typed(CMD_SET, 4'd1, MODE_OFF, MODE_OFF, 1'b0));
    plan.push_back(row_typed(CMD_SET, 4'd8, MODE_ON, MODE_ON, 1'b0));
    plan.push_back(row_typed(CMD_SET, 4'd0, MODE_ON, MODE_OFF, 1'b1));
    plan.push_back(row_typed(CMD_SET, 4'd9, MODE_OFF, MODE_OFF, 1'b1));
    plan.push_back(row_typed(CMD_SET, 4'd15, 3'd7, MODE_OFF, 1'b1));
    plan.push_back(row_item(CMD_SET, 4'd1, MODE_SLOW));
    plan.push_back(row_item(CMD_SET, 4'd2, MODE_MEDIUM));
    plan.push_back(row_item(CMD_SET, 4'd8, MODE_QUICK));
    plan.push_back(row_item(CMD_TICK, 4'd0, MODE_OFF));
    plan.push_back(row_item(CMD_SET, 4'd2, 3'd7));
    plan.push_back(row_item(CMD_RSVD, 4'd15, 3'd7));
    plan.push_back(row_typed(CMD_SET, 4'd1, MODE_ON, MODE_ON, 1'b0));
    // Device-driven flashing reports the flash code directly.
    plan.push_back(row_cfg(1'b0, EDGE_TIMING));
    plan.push_back(row_typed(CMD_SET, 4'd4, MODE_SLOW, MODE_SLOW, 1'b0));
    plan.push_back(row_typed(CMD_SET, 4'd5, MODE_MEDIUM, MODE_MEDIUM, 1'b0));
    plan.push_back(row_typed(CMD_SET, 4'd6, MODE_QUICK, MODE_QUICK, 1'b0));
    // Zero on time never starts; a zero off time toggles straight back on.
    plan.push_back(row_cfg(1'b1, EDGE_TIMING));
    plan.push_back(row_item(CMD_SET, 4'd7, MODE_SLOW));
    plan.push_back(row_item(CMD_SET, 4'd3, MODE_MEDIUM));
    plan.push_back(row_item(CMD_SET, 4'd2, MODE_QUICK));
    for (int j = 0; j < 4; j++) plan.push_back(row_item(CMD_TICK, 4'd0, MODE_OFF));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[j]) begin
      if (plan[j].is_cfg) load_regs(plan[j].sw, plan[j].timing);
      else send_cmd(plan[j]);
    end

    for (int k = 0; k < PHASE_COUNT; k++) begin
      sw = 1'b1;
      for (int j = 0; j < 6; j++) timing[j] = TICKS_W'($urandom_range(0, 3));
      case (k)
        2: begin
          sw = 1'b0;
          for (int j = 0; j < 6; j++) timing[j] = TICKS_W'($urandom);
        end
        3: timing = '1;
        4: timing = '0;
        6: begin
          sw = 1'($urandom_range(0, 1));
          for (int j = 0; j < 6; j++) timing[j] = TICKS_W'($urandom_range(0, 8));
        end
        default: ;
      endcase
      load_regs(sw, timing);

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        row  = '0;
        pick = $urandom_range(0, 99);
        if (pick < 45) row.cmd = CMD_TICK;
        else if (pick < 85) row.cmd = CMD_SET;
        else if (pick < 93) row.cmd = CMD_ALL_OFF;
        else row.cmd = CMD_RSVD;
        if ($urandom_range(0, 9) == 0) row.led = LED_W'($urandom);
        else row.led = LED_W'($urandom_range(1, LED_COUNT));
        pick = $urandom_range(0, 99);
        if (pick < 70) row.mode = MODE_W'($urandom_range(MODE_SLOW, MODE_QUICK));
        else if (pick < 90) row.mode = MODE_W'($urandom_range(MODE_OFF, MODE_ON));
        else row.mode = MODE_W'($urandom);
        send_cmd(row);
        counted++;
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
